// ===== hw/rtl/sws_pkg.sv =====
// shared types and constants of the sliding window sender
package sws_pkg;

  // field widths
  localparam int CMD_W       = 3;
  localparam int CHUNK_W     = 24;
  localparam int FSEQ_W      = 8;
  localparam int KIND_W      = 2;
  localparam int SEQ_OUT_W   = 8;
  localparam int TMO_W       = 16;
  localparam int MAX_RETRY_W = 8;
  localparam int ELAPSED_W   = 17;
  localparam int RETRY_W     = 9;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // command codes of the input item
  localparam logic [CMD_W-1:0] CMD_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OTHER = 3'd4;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SEND  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_RETRIES = 1'b1;

  localparam logic [TMO_W-1:0]       TIMEOUT_RESET     = 16'd250;
  localparam logic [MAX_RETRY_W-1:0] MAX_RETRIES_RESET = 8'd24;

  // controller to datapath
  typedef struct packed {
    logic acc_start;
    logic acc_tick;
    logic acc_frame;
    logic acc_ack;
    logic acc_nack;
    logic fill_step;
    logic walk_step;
    logic one_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic count_zero;
    logic timeout_hit;
    logic abort_hit;
    logic ack_match;
    logic ack_result;
    logic fill_last;
    logic walk_last;
    logic abort_pend;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/sws_ctrl.sv =====
// sequencing state machine of the sliding window sender
module sws_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [sws_pkg::CMD_W-1:0]   in_cmd,
  output logic                        in_ready,
  input  sws_pkg::sts_t               sts,
  output sws_pkg::cmd_t               cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_WALK = 4'b0100,
    S_ONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            sws_pkg::CMD_START: begin
              if (!sts.busy) begin
                cmd.acc_start = 1'b1;
                state_nxt     = sts.count_zero ? S_ONE : S_FILL;
              end
            end
            sws_pkg::CMD_TICK: begin
              if (sts.busy) begin
                cmd.acc_tick = 1'b1;
                if (sts.timeout_hit) begin
                  state_nxt = S_WALK;
                end else if (sts.abort_hit) begin
                  state_nxt = S_ONE;
                end
              end
            end
            sws_pkg::CMD_ACK: begin
              if (sts.busy) begin
                cmd.acc_frame = 1'b1;
                if (sts.ack_match) begin
                  cmd.acc_ack = 1'b1;
                  if (sts.ack_result) begin
                    state_nxt = S_ONE;
                  end
                end
              end
            end
            sws_pkg::CMD_NACK: begin
              if (sts.busy) begin
                cmd.acc_frame = 1'b1;
                cmd.acc_nack  = 1'b1;
                state_nxt     = S_WALK;
              end
            end
            sws_pkg::CMD_OTHER: begin
              if (sts.busy) begin
                cmd.acc_frame = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        if (sts.out_free) begin
          cmd.fill_step = 1'b1;
          if (sts.fill_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WALK: begin
        if (sts.out_free) begin
          cmd.walk_step = 1'b1;
          if (sts.walk_last) begin
            state_nxt = sts.abort_pend ? S_ONE : S_IDLE;
          end
        end
      end
      S_ONE: begin
        if (sts.out_free) begin
          cmd.one_step = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/sws_datapath.sv =====
// window, timer and retry state, config registers and result register
module sws_datapath #(
  parameter int WINDOW_SLOTS = 8,
  parameter int SEQ_MODULUS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sws_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sws_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [sws_pkg::CHUNK_W-1:0]       in_chunk_count,
  input  logic [sws_pkg::FSEQ_W-1:0]        in_frame_seq,
  input  sws_pkg::cmd_t                     cmd,
  output sws_pkg::sts_t                     sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sws_pkg::kind_t                    out_kind,
  output logic [sws_pkg::CHUNK_W-1:0]       out_chunk,
  output logic [sws_pkg::SEQ_OUT_W-1:0]     out_seq,
  output logic                              out_last
);

  localparam int WC_W  = $clog2(WINDOW_SLOTS + 1);
  localparam int SEQ_W = (SEQ_MODULUS > 2) ? $clog2(SEQ_MODULUS) : 1;
  localparam int CW    = sws_pkg::CHUNK_W;

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    return (s == SEQ_W'(SEQ_MODULUS - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [sws_pkg::TMO_W-1:0]       timeout_r, timeout_nxt;
  logic [sws_pkg::MAX_RETRY_W-1:0] max_retries_r, max_retries_nxt;
  logic                            busy_r, busy_nxt;
  logic [CW-1:0]                   head_r, head_nxt;
  logic [SEQ_W-1:0]                head_seq_r, head_seq_nxt;
  logic [CW-1:0]                   next_r, next_nxt;
  logic [SEQ_W-1:0]                next_seq_r, next_seq_nxt;
  logic [CW-1:0]                   total_r, total_nxt;
  logic [WC_W-1:0]                 wc_r, wc_nxt;
  logic [sws_pkg::ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;
  logic [sws_pkg::RETRY_W-1:0]     retry_r, retry_nxt;
  logic [CW-1:0]                   walk_chunk_r, walk_chunk_nxt;
  logic [SEQ_W-1:0]                walk_seq_r, walk_seq_nxt;
  logic [WC_W-1:0]                 walk_cnt_r, walk_cnt_nxt;
  sws_pkg::kind_t                  pend_kind_r, pend_kind_nxt;
  logic                            abort_pend_r, abort_pend_nxt;
  logic                            out_valid_r, out_valid_nxt;
  sws_pkg::kind_t                  out_kind_r, out_kind_nxt;
  logic [CW-1:0]                   out_chunk_r, out_chunk_nxt;
  logic [sws_pkg::SEQ_OUT_W-1:0]   out_seq_r, out_seq_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [sws_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic [sws_pkg::RETRY_W-1:0]   retry_inc, retry_new;
  logic                          timeout_hit, abort_hit, more_chunks;
  logic                          fill_last, walk_last, out_free, step;

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign timeout_hit = elapsed_inc > sws_pkg::ELAPSED_W'(timeout_r);
  assign retry_inc   = (retry_r == '1) ? retry_r : retry_r + 1'b1;
  assign retry_new   = timeout_hit ? retry_inc : retry_r;
  assign abort_hit   = retry_new > sws_pkg::RETRY_W'(max_retries_r);
  assign more_chunks = next_r < total_r;
  assign fill_last   = (({1'b0, wc_r} + 1'b1) == (WC_W + 1)'(WINDOW_SLOTS))
                    || ((next_r + 1'b1) == total_r);
  assign walk_last   = ({1'b0, walk_cnt_r} + 1'b1) == {1'b0, wc_r};
  assign out_free    = !out_valid_r || out_ready;
  assign step        = cmd.fill_step || cmd.walk_step || cmd.one_step;

  always_comb begin
    sts             = '0;
    sts.busy        = busy_r;
    sts.count_zero  = (in_chunk_count == '0);
    sts.timeout_hit = timeout_hit;
    sts.abort_hit   = abort_hit;
    sts.ack_match   = (wc_r != '0)
                   && (in_frame_seq == sws_pkg::FSEQ_W'(head_seq_r));
    sts.ack_result  = more_chunks || (wc_r == WC_W'(1));
    sts.fill_last   = fill_last;
    sts.walk_last   = walk_last;
    sts.abort_pend  = abort_pend_r;
    sts.out_free    = out_free;
  end

  always_comb begin
    timeout_nxt     = timeout_r;
    max_retries_nxt = max_retries_r;
    busy_nxt        = busy_r;
    head_nxt        = head_r;
    head_seq_nxt    = head_seq_r;
    next_nxt        = next_r;
    next_seq_nxt    = next_seq_r;
    total_nxt       = total_r;
    wc_nxt          = wc_r;
    elapsed_nxt     = elapsed_r;
    retry_nxt       = retry_r;
    walk_chunk_nxt  = walk_chunk_r;
    walk_seq_nxt    = walk_seq_r;
    walk_cnt_nxt    = walk_cnt_r;
    pend_kind_nxt   = pend_kind_r;
    abort_pend_nxt  = abort_pend_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_chunk_nxt   = out_chunk_r;
    out_seq_nxt     = out_seq_r;
    out_last_nxt    = out_last_r;

    if (cfg_we) begin
      case (cfg_addr)
        sws_pkg::REG_TIMEOUT:     timeout_nxt = cfg_wdata;
        sws_pkg::REG_MAX_RETRIES: max_retries_nxt = cfg_wdata[sws_pkg::MAX_RETRY_W-1:0];
        default: ;
      endcase
    end

    if (cmd.acc_start) begin
      total_nxt     = in_chunk_count;
      head_nxt      = '0;
      head_seq_nxt  = '0;
      next_nxt      = '0;
      next_seq_nxt  = '0;
      wc_nxt        = '0;
      elapsed_nxt   = '0;
      retry_nxt     = '0;
      busy_nxt      = (in_chunk_count != '0);
      pend_kind_nxt = sws_pkg::KIND_DONE;
    end

    if (cmd.acc_tick) begin
      retry_nxt      = retry_new;
      abort_pend_nxt = abort_hit;
      pend_kind_nxt  = sws_pkg::KIND_ABORT;
      if (timeout_hit) begin
        elapsed_nxt    = '0;
        walk_chunk_nxt = head_r;
        walk_seq_nxt   = head_seq_r;
        walk_cnt_nxt   = '0;
      end else begin
        elapsed_nxt = elapsed_inc;
      end
    end

    if (cmd.acc_frame) begin
      retry_nxt = '0;
    end

    if (cmd.acc_ack) begin
      elapsed_nxt   = '0;
      head_nxt      = head_r + 1'b1;
      head_seq_nxt  = seq_inc(head_seq_r);
      wc_nxt        = wc_r - 1'b1;
      pend_kind_nxt = more_chunks ? sws_pkg::KIND_SEND : sws_pkg::KIND_DONE;
    end

    if (cmd.acc_nack) begin
      elapsed_nxt    = '0;
      walk_chunk_nxt = head_r;
      walk_seq_nxt   = head_seq_r;
      walk_cnt_nxt   = '0;
      abort_pend_nxt = 1'b0;
    end

    if (cmd.fill_step) begin
      out_kind_nxt  = sws_pkg::KIND_SEND;
      out_chunk_nxt = next_r;
      out_seq_nxt   = sws_pkg::SEQ_OUT_W'(next_seq_r);
      out_last_nxt  = fill_last;
      next_nxt      = next_r + 1'b1;
      next_seq_nxt  = seq_inc(next_seq_r);
      wc_nxt        = wc_r + 1'b1;
    end

    if (cmd.walk_step) begin
      out_kind_nxt   = sws_pkg::KIND_SEND;
      out_chunk_nxt  = walk_chunk_r;
      out_seq_nxt    = sws_pkg::SEQ_OUT_W'(walk_seq_r);
      out_last_nxt   = walk_last && !abort_pend_r;
      walk_chunk_nxt = walk_chunk_r + 1'b1;
      walk_seq_nxt   = seq_inc(walk_seq_r);
      walk_cnt_nxt   = walk_cnt_r + 1'b1;
    end

    if (cmd.one_step) begin
      out_kind_nxt  = pend_kind_r;
      out_chunk_nxt = '0;
      out_seq_nxt   = '0;
      out_last_nxt  = 1'b1;
      case (pend_kind_r)
        sws_pkg::KIND_SEND: begin
          out_chunk_nxt = next_r;
          out_seq_nxt   = sws_pkg::SEQ_OUT_W'(next_seq_r);
          next_nxt      = next_r + 1'b1;
          next_seq_nxt  = seq_inc(next_seq_r);
          wc_nxt        = wc_r + 1'b1;
        end
        sws_pkg::KIND_DONE: begin
          busy_nxt    = 1'b0;
          elapsed_nxt = '0;
        end
        sws_pkg::KIND_ABORT: begin
          busy_nxt    = 1'b0;
          wc_nxt      = '0;
          retry_nxt   = '0;
          elapsed_nxt = '0;
        end
        default: ;
      endcase
    end

    if (step) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= sws_pkg::TIMEOUT_RESET;
      max_retries_r <= sws_pkg::MAX_RETRIES_RESET;
      busy_r        <= 1'b0;
      head_r        <= '0;
      head_seq_r    <= '0;
      next_r        <= '0;
      next_seq_r    <= '0;
      total_r       <= '0;
      wc_r          <= '0;
      elapsed_r     <= '0;
      retry_r       <= '0;
      pend_kind_r   <= sws_pkg::KIND_DONE;
      abort_pend_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      timeout_r     <= timeout_nxt;
      max_retries_r <= max_retries_nxt;
      busy_r        <= busy_nxt;
      head_r        <= head_nxt;
      head_seq_r    <= head_seq_nxt;
      next_r        <= next_nxt;
      next_seq_r    <= next_seq_nxt;
      total_r       <= total_nxt;
      wc_r          <= wc_nxt;
      elapsed_r     <= elapsed_nxt;
      retry_r       <= retry_nxt;
      pend_kind_r   <= pend_kind_nxt;
      abort_pend_r  <= abort_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_chunk_r <= walk_chunk_nxt;
    walk_seq_r   <= walk_seq_nxt;
    walk_cnt_r   <= walk_cnt_nxt;
    out_kind_r   <= out_kind_nxt;
    out_chunk_r  <= out_chunk_nxt;
    out_seq_r    <= out_seq_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_chunk = out_chunk_r;
  assign out_seq   = out_seq_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/sliding_window_sender.sv =====
// top level of the go-back-n sliding window sender
//
// usage
// - input stream carries events: start (with a chunk count), millisecond tick,
//   ack frame (with its sequence number), nack frame, other frame
// - output stream carries results: send request for a chunk (index and
//   sequence number), transfer done, or transfer aborted; tlast marks the
//   final result caused by one input transfer
// - config port writes the timeout in ms and the retry limit; the user must
//   write them only while idle, which the block itself leaves unchecked
// timing
// - an input transfer is decoded in the cycle it is taken; each result then
//   leaves the single output register, one per cycle while the receiver
//   does not stall
// - a new input is taken once the last result of the previous one is loaded
//   into the output register, while that result may still wait to be taken
// reset
// - idle, empty window, timeout 250 ms, retry limit 24, output stream empty
// stalls
// - a stalled receiver holds the result and pauses the window fill or walk;
//   nothing is dropped and in_tready stays low until the item is finished
module sliding_window_sender #(
  parameter int WINDOW_SLOTS = 8,
  parameter int SEQ_MODULUS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [sws_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sws_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // event stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sws_pkg::IN_TDATA_W-1:0]      in_tdata,   // cmd, chunk_count, frame_seq
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sws_pkg::OUT_TDATA_W-1:0]     out_tdata,  // chunk_index, seq_out
  output logic [sws_pkg::KIND_W-1:0]          out_tuser,  // kind
  output logic                                out_tlast
);

  sws_pkg::cmd_t                   cmd;
  sws_pkg::sts_t                   sts;
  sws_pkg::kind_t                  out_kind;
  logic [sws_pkg::CHUNK_W-1:0]     out_chunk;
  logic [sws_pkg::SEQ_OUT_W-1:0]   out_seq;

  // unpack the event fields, lowest bits first
  logic [sws_pkg::CMD_W-1:0]   in_cmd;
  logic [sws_pkg::CHUNK_W-1:0] in_chunk_count;
  logic [sws_pkg::FSEQ_W-1:0]  in_frame_seq;

  assign in_cmd         = in_tdata[2:0];
  assign in_chunk_count = in_tdata[26:3];
  assign in_frame_seq   = in_tdata[34:27];

  // sequencer: decides which update and which walk runs per cycle
  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_cmd),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window state, timer, retry counter and result register
  sws_datapath #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .SEQ_MODULUS  (SEQ_MODULUS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_chunk_count (in_chunk_count),
    .in_frame_seq   (in_frame_seq),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_kind       (out_kind),
    .out_chunk      (out_chunk),
    .out_seq        (out_seq),
    .out_last       (out_tlast)
  );

  // pack the result fields, chunk index in the low bits
  assign out_tdata = {out_seq, out_chunk};
  assign out_tuser = out_kind;

endmodule

// ===== hw/rtl/sws_checker.sv =====
// port-level checks of the sliding window sender, bound to the top level
module sws_port_checks (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sws_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [sws_pkg::KIND_W-1:0]        out_tuser,
  input logic                              out_tlast
);

  // no result survives a reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result stream not empty after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // done and abort always close a run and carry no chunk
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != sws_pkg::KIND_SEND |-> out_tlast && out_tdata == '0)
    else $error("done or abort result malformed");

  // no new event is taken while a run of results is unfinished
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("event taken in the middle of a result run");

endmodule

bind sliding_window_sender sws_port_checks u_sws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
